// File: rtl/core/rmbw_pkg.sv
// Shared constants for the rotate/mirror blit address walker.
package rmbw_pkg;

  // Field and register widths
  localparam int ADDR_W        = 32;
  localparam int STRIDE_W      = 17;
  localparam int ORIGIN_W      = 12;
  localparam int DIM_REG_W     = 13;
  localparam int ORIENT_W      = 3;
  localparam int DOFF_W        = 26;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 64;
  localparam int PIXEL_BYTES   = 4;

  // Default parameter values
  localparam int MAX_DIM_DEF   = 4096;
  localparam int ADDR_BITS_DEF = 32;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_STRIDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION   = 3'd6;

  // Register reset values
  localparam logic [ADDR_W-1:0]    RST_SOURCE_BASE   = '0;
  localparam logic [STRIDE_W-1:0]  RST_SOURCE_STRIDE = 17'd4096;
  localparam logic [ORIGIN_W-1:0]  RST_REGION_X      = '0;
  localparam logic [ORIGIN_W-1:0]  RST_REGION_Y      = '0;
  localparam logic [DIM_REG_W-1:0] RST_REGION_WIDTH  = 13'd1;
  localparam logic [DIM_REG_W-1:0] RST_REGION_HEIGHT = 13'd1;

  // Orientation codes
  localparam logic [ORIENT_W-1:0] ORI_NONE          = 3'd0;
  localparam logic [ORIENT_W-1:0] ORI_ROT90         = 3'd1;
  localparam logic [ORIENT_W-1:0] ORI_ROT180        = 3'd2;
  localparam logic [ORIENT_W-1:0] ORI_ROT270        = 3'd3;
  localparam logic [ORIENT_W-1:0] ORI_MIRROR        = 3'd4;
  localparam logic [ORIENT_W-1:0] ORI_MIRROR_ROT90  = 3'd5;
  localparam logic [ORIENT_W-1:0] ORI_MIRROR_ROT180 = 3'd6;
  localparam logic [ORIENT_W-1:0] ORI_MIRROR_ROT270 = 3'd7;

endpackage

// File: rtl/core/rotate_mirror_blit_address_walker_top.sv
// Rotate/mirror blit address walker: source address and destination offset per pixel.
//
// Usage
//   Configuration: cfg_valid/cfg_index/cfg_data write one register per transfer;
//   cfg_ready is always high. Write only while the walker is idle.
//   Input: each transfer on in_* asks for the next destination pixel. in_tdata[0]
//   set restarts the walk at the first pixel; a walk also starts on its own after
//   reset and after the final pixel of the region.
//   Output: one transfer on out_* per input transfer, carrying the source byte
//   address and destination byte offset. out_tuser marks the end of a destination
//   row, out_tlast the final pixel of the region.
// Timing
//   Each pixel passes an input register, then the step adders into the output
//   register. Throughput is one pixel per clock while out_tready stays high, set
//   by the column/row step update of the walk state. The first-row address comes
//   from a registered stride product, so a new configuration is usable once that
//   product has been registered after its write.
// Reset and stalls
//   rst_n (synchronous, active low) restores register defaults and empties both
//   stages. When out_tready is low the result holds and in_tready drops once the
//   input register is also full.
module rotate_mirror_blit_address_walker_top #(
  parameter int MAX_DIM   = rmbw_pkg::MAX_DIM_DEF,
  parameter int ADDR_BITS = rmbw_pkg::ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rmbw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmbw_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rmbw_pkg::IN_TDATA_W-1:0]     in_tdata,  // [0] restart, [7:1] zero
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rmbw_pkg::OUT_TDATA_W-1:0]    out_tdata, // [31:0] source_address,
                                                         // [57:32] dest_offset, [63:58] zero
  output logic                                out_tuser, // [0] row_end
  output logic                                out_tlast  // last
);

  localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int DW     = (DIM_W > rmbw_pkg::DIM_REG_W) ? DIM_W : rmbw_pkg::DIM_REG_W;
  localparam int SW     = DW + 1;
  localparam int PW     = SW + rmbw_pkg::STRIDE_W;
  localparam int DOFF_W = rmbw_pkg::DOFF_W;
  localparam int AOUT_W = rmbw_pkg::ADDR_W;

  // Configuration registers
  logic [rmbw_pkg::ADDR_W-1:0]    base_r;
  logic [rmbw_pkg::STRIDE_W-1:0]  stride_r;
  logic [rmbw_pkg::ORIGIN_W-1:0]  reg_x_r;
  logic [rmbw_pkg::ORIGIN_W-1:0]  reg_y_r;
  logic [rmbw_pkg::DIM_REG_W-1:0] width_r;
  logic [rmbw_pkg::DIM_REG_W-1:0] height_r;
  logic [rmbw_pkg::ORIENT_W-1:0]  orient_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= rmbw_pkg::RST_SOURCE_BASE;
      stride_r <= rmbw_pkg::RST_SOURCE_STRIDE;
      reg_x_r  <= rmbw_pkg::RST_REGION_X;
      reg_y_r  <= rmbw_pkg::RST_REGION_Y;
      width_r  <= rmbw_pkg::RST_REGION_WIDTH;
      height_r <= rmbw_pkg::RST_REGION_HEIGHT;
      orient_r <= rmbw_pkg::ORI_NONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rmbw_pkg::REG_SOURCE_BASE:   base_r   <= cfg_data[rmbw_pkg::ADDR_W-1:0];
        rmbw_pkg::REG_SOURCE_STRIDE: stride_r <= cfg_data[rmbw_pkg::STRIDE_W-1:0];
        rmbw_pkg::REG_REGION_X:      reg_x_r  <= cfg_data[rmbw_pkg::ORIGIN_W-1:0];
        rmbw_pkg::REG_REGION_Y:      reg_y_r  <= cfg_data[rmbw_pkg::ORIGIN_W-1:0];
        rmbw_pkg::REG_REGION_WIDTH:  width_r  <= cfg_data[rmbw_pkg::DIM_REG_W-1:0];
        rmbw_pkg::REG_REGION_HEIGHT: height_r <= cfg_data[rmbw_pkg::DIM_REG_W-1:0];
        rmbw_pkg::REG_ORIENTATION:   orient_r <= cfg_data[rmbw_pkg::ORIENT_W-1:0];
        default: ;
      endcase
    end
  end

  // Region size saturated to 1..MAX_DIM
  logic [DW-1:0] w_cl;
  logic [DW-1:0] h_cl;
  logic [DW-1:0] w_ext;
  logic [DW-1:0] h_ext;

  always_comb begin
    w_ext = DW'(width_r);
    h_ext = DW'(height_r);
    if (w_ext == '0)              w_cl = DW'(1);
    else if (w_ext > DW'(MAX_DIM)) w_cl = DW'(MAX_DIM);
    else                          w_cl = w_ext;
    if (h_ext == '0)              h_cl = DW'(1);
    else if (h_ext > DW'(MAX_DIM)) h_cl = DW'(MAX_DIM);
    else                          h_cl = h_ext;
  end

  // Source corner of the first destination pixel
  logic [SW-1:0] sx_c;
  logic [SW-1:0] sy_c;
  logic [SW-1:0] x_far;
  logic [SW-1:0] y_far;

  assign x_far = SW'(reg_x_r) + SW'(w_cl) - SW'(1);
  assign y_far = SW'(reg_y_r) + SW'(h_cl) - SW'(1);

  always_comb begin
    unique case (orient_r) inside
      rmbw_pkg::ORI_ROT90, rmbw_pkg::ORI_MIRROR_ROT180: begin
        sx_c = SW'(reg_x_r);
        sy_c = y_far;
      end
      rmbw_pkg::ORI_ROT180, rmbw_pkg::ORI_MIRROR_ROT90: begin
        sx_c = x_far;
        sy_c = y_far;
      end
      rmbw_pkg::ORI_ROT270, rmbw_pkg::ORI_MIRROR: begin
        sx_c = x_far;
        sy_c = SW'(reg_y_r);
      end
      default: begin
        sx_c = SW'(reg_x_r);
        sy_c = SW'(reg_y_r);
      end
    endcase
  end

  // Registered row product and column part of the first-row address
  logic [PW-1:0]        prod_r;
  logic [ADDR_BITS-1:0] bx_r;

  always_ff @(posedge clk) begin
    prod_r <= PW'(sy_c) * PW'(stride_r);
    bx_r   <= ADDR_BITS'(base_r) + ADDR_BITS'({sx_c, 2'b00});
  end

  logic [ADDR_BITS-1:0] first_c;
  assign first_c = ADDR_BITS'(prod_r) + bx_r;

  // Step sizes within a row and between rows
  logic [ADDR_BITS-1:0] pix4;
  logic [ADDR_BITS-1:0] s4;
  logic [ADDR_BITS-1:0] sfull;
  logic [ADDR_BITS-1:0] col_step;
  logic [ADDR_BITS-1:0] row_incr;

  assign pix4  = ADDR_BITS'(rmbw_pkg::PIXEL_BYTES);
  assign s4    = ADDR_BITS'({stride_r[rmbw_pkg::STRIDE_W-1:2], 2'b00});
  assign sfull = ADDR_BITS'(stride_r);

  always_comb begin
    unique case (orient_r) inside
      rmbw_pkg::ORI_NONE, rmbw_pkg::ORI_MIRROR_ROT180:  col_step = pix4;
      rmbw_pkg::ORI_ROT180, rmbw_pkg::ORI_MIRROR:       col_step = ADDR_BITS'(0) - pix4;
      rmbw_pkg::ORI_ROT270, rmbw_pkg::ORI_MIRROR_ROT270: col_step = s4;
      default:                                          col_step = ADDR_BITS'(0) - s4;
    endcase
    unique case (orient_r) inside
      rmbw_pkg::ORI_NONE, rmbw_pkg::ORI_MIRROR:         row_incr = sfull;
      rmbw_pkg::ORI_ROT180, rmbw_pkg::ORI_MIRROR_ROT180: row_incr = ADDR_BITS'(0) - sfull;
      rmbw_pkg::ORI_ROT90, rmbw_pkg::ORI_MIRROR_ROT270: row_incr = pix4;
      default:                                          row_incr = ADDR_BITS'(0) - pix4;
    endcase
  end

  // Destination size: axes swap for the quarter-turn transforms
  logic [DW-1:0] dst_w;
  logic [DW-1:0] dst_h;
  assign dst_w = orient_r[0] ? h_cl : w_cl;
  assign dst_h = orient_r[0] ? w_cl : h_cl;

  // Input register and pipeline handshake
  logic item_v_r;
  logic restart_r;
  logic out_v_r;
  logic advance;

  assign advance   = item_v_r && (!out_v_r || out_tready);
  assign in_tready = !item_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tready) begin
      item_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      restart_r <= in_tdata[0];
    end
  end

  // Walk state
  logic [CNT_W-1:0]     col_r;
  logic [CNT_W-1:0]     row_r;
  logic [ADDR_BITS-1:0] row_start_r;
  logic [ADDR_BITS-1:0] pix_r;
  logic [DOFF_W-1:0]    doff_r;
  logic                 active_r;

  logic                 start_c;
  logic [CNT_W-1:0]     cur_col;
  logic [CNT_W-1:0]     cur_row;
  logic [ADDR_BITS-1:0] cur_rs;
  logic [ADDR_BITS-1:0] cur_pix;
  logic [DOFF_W-1:0]    cur_doff;
  logic                 row_end_c;
  logic                 last_c;

  logic [CNT_W-1:0]     col_nxt;
  logic [CNT_W-1:0]     row_nxt;
  logic [ADDR_BITS-1:0] row_start_nxt;
  logic [ADDR_BITS-1:0] pix_nxt;
  logic [DOFF_W-1:0]    doff_nxt;
  logic                 active_nxt;

  always_comb begin
    // current pixel, taking a walk start into account
    start_c   = restart_r || !active_r;
    cur_col   = start_c ? '0 : col_r;
    cur_row   = start_c ? '0 : row_r;
    cur_rs    = start_c ? first_c : row_start_r;
    cur_pix   = start_c ? first_c : pix_r;
    cur_doff  = start_c ? '0 : doff_r;
    row_end_c = (SW'(cur_col) + SW'(1)) >= SW'(dst_w);
    last_c    = row_end_c && ((SW'(cur_row) + SW'(1)) >= SW'(dst_h));

    // next pixel
    col_nxt       = cur_col;
    row_nxt       = cur_row;
    row_start_nxt = cur_rs;
    pix_nxt       = cur_pix;
    doff_nxt      = cur_doff + DOFF_W'(rmbw_pkg::PIXEL_BYTES);
    active_nxt    = !last_c;
    if (last_c) begin
      doff_nxt = cur_doff;
    end else if (row_end_c) begin
      col_nxt       = '0;
      row_nxt       = cur_row + CNT_W'(1);
      row_start_nxt = cur_rs + row_incr;
      pix_nxt       = cur_rs + row_incr;
    end else begin
      col_nxt = cur_col + CNT_W'(1);
      pix_nxt = cur_pix + col_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (advance) begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      row_start_r <= row_start_nxt;
      pix_r       <= pix_nxt;
      doff_r      <= doff_nxt;
    end
  end

  // Output register
  logic [AOUT_W-1:0] out_src_r;
  logic [DOFF_W-1:0] out_doff_r;
  logic              out_row_end_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_src_r     <= AOUT_W'(cur_pix);
      out_doff_r    <= cur_doff;
      out_row_end_r <= row_end_c;
      out_last_r    <= last_c;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(rmbw_pkg::OUT_TDATA_W - DOFF_W - AOUT_W)'(0), out_doff_r, out_src_r};
  assign out_tuser  = out_row_end_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // the final pixel always closes a destination row
  a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_last_r |-> out_row_end_r)
    else $error("last pixel without row end");

  // a walk ends exactly after its final pixel
  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_c |=> !active_r)
    else $error("walk still active after last pixel");

  a_walk_runs: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !last_c |=> active_r)
    else $error("walk stopped before last pixel");

  // a new walk starts at destination offset zero
  a_start_offset: assert property (@(posedge clk) disable iff (!rst_n)
    advance && start_c |=> out_doff_r == '0)
    else $error("walk start with nonzero destination offset");

  // destination offsets stay pixel aligned
  a_doff_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_doff_r[1:0] == 2'b00)
    else $error("destination offset not pixel aligned");
`endif

endmodule
